[rtl/core/scancode_to_ascii_with_modifiers_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scancode translator
// Shared same-cycle and next-cycle implication checks, clocked on clk,
// disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_WITH_MODIFIERS_UNIT_ASSERT_SVH
`define SCANCODE_TO_ASCII_WITH_MODIFIERS_UNIT_ASSERT_SVH

// same-cycle implication
`define SC2A_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scancode translator check failed");

// next-cycle implication
`define SC2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scancode translator check failed");

`endif

[rtl/core/sc2a_pkg.sv]
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, scancodes and key maps for the set-1 scancode translator.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  typedef struct packed {
    logic [7:0] scan_byte;
    logic       editor_focused;
  } in_word_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] char_code;
    logic [1:0] tab_index;
  } out_word_t;

  typedef struct packed {
    logic      has_event;
    out_word_t word;
  } xlate_t;

  localparam logic [1:0] KIND_EDITOR  = 2'd0;
  localparam logic [1:0] KIND_CONSOLE = 2'd1;
  localparam logic [1:0] KIND_SAVE    = 2'd2;
  localparam logic [1:0] KIND_TAB     = 2'd3;

  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_KEY_S  = 7'h1F;
  localparam logic [6:0] SC_KEY_1  = 7'h02;
  localparam logic [6:0] SC_KEY_4  = 7'h05;

  localparam int unsigned MapDepth = 58;

  localparam logic [6:0] PLAIN_MAP [MapDepth] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFT_MAP [MapDepth] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

endpackage

[rtl/core/sc2a_in_stage.sv]
// ----------------------------------------------------------------------------
// sc2a_in_stage
// Input register: captures one key word and holds it until it is consumed.
// ----------------------------------------------------------------------------
module sc2a_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_stall,
  input  sc2a_pkg::in_word_t key_word,
  input  logic              adv,
  output logic              q_valid,
  output sc2a_pkg::in_word_t q_word
);
  import sc2a_pkg::*;

  assign key_stall = q_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!key_stall) begin
      q_valid <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!key_stall && key_valid) begin
      q_word <= key_word;
    end
  end

endmodule

[rtl/core/sc2a_xlate.sv]
// ----------------------------------------------------------------------------
// sc2a_xlate
// Modifier flags and key translation for one registered scancode.
// ----------------------------------------------------------------------------
module sc2a_xlate (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  sc2a_pkg::in_word_t word,
  output sc2a_pkg::xlate_t   result
);
  import sc2a_pkg::*;

  logic       shift_held;
  logic       ctrl_held;
  logic       caps_on;
  logic       shift_held_next;
  logic       ctrl_held_next;
  logic       caps_on_next;
  logic       brk;
  logic [6:0] code;
  logic       is_shift;
  logic       is_ctrl;
  logic       is_caps;
  logic       is_tab_key;
  logic [6:0] plain_ch;
  logic [6:0] shift_ch;
  logic [6:0] map_ch;
  logic [6:0] ch;

  assign brk        = word.scan_byte[7];
  assign code       = word.scan_byte[6:0];
  assign is_shift   = (code == SC_LSHIFT) || (code == SC_RSHIFT);
  assign is_ctrl    = (code == SC_CTRL);
  assign is_caps    = (code == SC_CAPS);
  assign is_tab_key = (code >= SC_KEY_1) && (code <= SC_KEY_4);

  assign plain_ch = (code < 7'(MapDepth)) ? PLAIN_MAP[code[5:0]] : 7'h00;
  assign shift_ch = (code < 7'(MapDepth)) ? SHIFT_MAP[code[5:0]] : 7'h00;
  assign map_ch   = shift_held ? shift_ch : plain_ch;

  always_comb begin
    ch = map_ch;
    if (caps_on && map_ch >= 7'h61 && map_ch <= 7'h7A) begin
      ch = {map_ch[6], 1'b0, map_ch[4:0]};
    end else if (caps_on && !shift_held && map_ch >= 7'h41 && map_ch <= 7'h5A) begin
      ch = {map_ch[6], 1'b1, map_ch[4:0]};
    end
  end

  always_comb begin
    shift_held_next = shift_held;
    ctrl_held_next  = ctrl_held;
    caps_on_next    = caps_on;
    if (brk) begin
      if (is_shift) shift_held_next = 1'b0;
      if (is_ctrl)  ctrl_held_next  = 1'b0;
    end else if (is_shift) begin
      shift_held_next = 1'b1;
    end else if (is_ctrl) begin
      ctrl_held_next = 1'b1;
    end else if (is_caps) begin
      caps_on_next = !caps_on;
    end
  end

  always_comb begin
    result.has_event       = 1'b0;
    result.word.event_kind = word.editor_focused ? KIND_EDITOR : KIND_CONSOLE;
    result.word.char_code  = ch;
    result.word.tab_index  = 2'd0;
    priority if (brk || is_shift || is_ctrl || is_caps) begin
      result.has_event = 1'b0;
    end else if (ctrl_held && code == SC_KEY_S) begin
      result.has_event       = word.editor_focused;
      result.word.event_kind = KIND_SAVE;
      result.word.char_code  = 7'h00;
    end else if (ctrl_held && is_tab_key) begin
      result.has_event       = 1'b1;
      result.word.event_kind = KIND_TAB;
      result.word.char_code  = 7'h00;
      result.word.tab_index  = code[1:0] - 2'd2;
    end else begin
      result.has_event = (ch != 7'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
      caps_on    <= 1'b0;
    end else if (fire) begin
      shift_held <= shift_held_next;
      ctrl_held  <= ctrl_held_next;
      caps_on    <= caps_on_next;
    end
  end

endmodule

[rtl/core/sc2a_out_stage.sv]
// ----------------------------------------------------------------------------
// sc2a_out_stage
// Result register: holds one event word until the consumer takes it.
// ----------------------------------------------------------------------------
module sc2a_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  sc2a_pkg::xlate_t    result,
  output logic                free,
  output logic                event_valid,
  input  logic                event_stall,
  output sc2a_pkg::out_word_t event_word
);
  import sc2a_pkg::*;

  assign free = !event_valid || !event_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (free) begin
      event_valid <= fire && result.has_event;
    end
  end

  always_ff @(posedge clk) begin
    if (free && fire && result.has_event) begin
      event_word <= result.word;
    end
  end

endmodule

[rtl/core/scancode_to_ascii_with_modifiers_unit.sv]
// ----------------------------------------------------------------------------
// scancode_to_ascii_with_modifiers_unit
// Set-1 keyboard scancode to ASCII translator with shift, ctrl and caps lock.
// ----------------------------------------------------------------------------
// Takes one scancode word per cycle unless the event side stalls; each word's
// event is presented by the result register, which takes it from the input
// register, and a word that yields no event (releases, modifiers, unmapped keys,
// ctrl+S without editor focus) only updates the modifier flags. One input
// register and one result register bound the translation logic, so throughput
// is one word per cycle whenever the event side takes words as they come.
module scancode_to_ascii_with_modifiers_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_valid,
  output logic                key_stall,
  input  sc2a_pkg::in_word_t  key_word,
  output logic                event_valid,
  input  logic                event_stall,
  output sc2a_pkg::out_word_t event_word
);
  import sc2a_pkg::*;

  logic     q_valid;
  in_word_t q_word;
  logic     out_free;
  logic     fire;
  xlate_t   result;

  assign fire = q_valid && out_free;

  sc2a_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_word  (key_word),
    .adv       (fire),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  sc2a_xlate u_xlate (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .word   (q_word),
    .result (result)
  );

  sc2a_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .result      (result),
    .free        (out_free),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_word  (event_word)
  );

`include "scancode_to_ascii_with_modifiers_unit_assert.svh"

  `SC2A_ASSERT_NOW(a_char_nonzero,
    event_valid && (event_word.event_kind == KIND_EDITOR ||
                    event_word.event_kind == KIND_CONSOLE),
    event_word.char_code != 7'h00 && event_word.tab_index == 2'd0)
  `SC2A_ASSERT_NOW(a_cmd_no_char,
    event_valid && (event_word.event_kind == KIND_SAVE ||
                    event_word.event_kind == KIND_TAB),
    event_word.char_code == 7'h00)
  `SC2A_ASSERT_NOW(a_save_no_tab,
    event_valid && event_word.event_kind == KIND_SAVE,
    event_word.tab_index == 2'd0)
  `SC2A_ASSERT_NOW(a_stall_backs_up,
    q_valid && event_valid && event_stall, key_stall)
  `SC2A_ASSERT_NEXT(a_fire_event,
    fire && result.has_event, event_valid)

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-1 scancode translator. A queue of key
// words (directed modifier and chord cases, then random key sequences) feeds
// a clocked driver; a clocked monitor compares every event word against a
// local translator model that tracks shift, ctrl and caps lock. Both sides
// idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import sc2a_pkg::*;

  localparam int unsigned RandomWords = 1720;
  localparam int unsigned TailWords   = 150;
  localparam int unsigned MaxReports  = 10;

  localparam logic [7:0] BREAK_BIT = 8'h80;

  localparam logic [6:0] KEY_Q     = 7'h10;
  localparam logic [6:0] KEY_A     = 7'h1E;
  localparam logic [6:0] KEY_ALT   = 7'h38;
  localparam logic [6:0] KEY_SPACE = 7'h39;
  localparam logic [6:0] KEY_TOP   = 7'h7F;

  localparam logic [6:0] KEYS_PLAIN [0:57] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] KEYS_SHIFTED [0:57] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      key_valid = 1'b0;
  logic      key_stall;
  in_word_t  key_word = '0;
  logic      event_valid;
  logic      event_stall = 1'b0;
  out_word_t event_word;

  in_word_t  key_backlog [$];
  out_word_t expected_events [$];

  logic shift_held = 1'b0;
  logic ctrl_held  = 1'b0;
  logic caps_on    = 1'b0;

  int unsigned words_sent = 0;
  int unsigned key_gap    = 0;
  int unsigned stall_gap  = 0;
  int unsigned error_count = 0;

  scancode_to_ascii_with_modifiers_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .key_word    (key_word),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_word  (event_word)
  );

  function automatic logic translate_key(input in_word_t w, output out_word_t ev);
    logic [6:0] code;
    logic [6:0] ch;
    ev = '0;
    code = w.scan_byte[6:0];
    if (w.scan_byte[7]) begin
      if (code == SC_LSHIFT || code == SC_RSHIFT) shift_held = 1'b0;
      if (code == SC_CTRL) ctrl_held = 1'b0;
      return 1'b0;
    end
    if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_held = 1'b1;
      return 1'b0;
    end
    if (code == SC_CTRL) begin
      ctrl_held = 1'b1;
      return 1'b0;
    end
    if (code == SC_CAPS) begin
      caps_on = !caps_on;
      return 1'b0;
    end
    if (ctrl_held && code == SC_KEY_S) begin
      if (!w.editor_focused) return 1'b0;
      ev.event_kind = KIND_SAVE;
      return 1'b1;
    end
    if (ctrl_held && code >= SC_KEY_1 && code <= SC_KEY_4) begin
      ev.event_kind = KIND_TAB;
      ev.tab_index = 2'(code - SC_KEY_1);
      return 1'b1;
    end
    ch = 7'h00;
    if (code < 7'd58) ch = shift_held ? KEYS_SHIFTED[code] : KEYS_PLAIN[code];
    if (caps_on && ch >= 7'h61 && ch <= 7'h7A) begin
      ch = ch - 7'h20;
    end else if (caps_on && ch >= 7'h41 && ch <= 7'h5A && !shift_held) begin
      ch = ch + 7'h20;
    end
    if (ch == 7'h00) return 1'b0;
    ev.event_kind = w.editor_focused ? KIND_EDITOR : KIND_CONSOLE;
    ev.char_code = ch;
    return 1'b1;
  endfunction

  task automatic push_key(input logic [7:0] scan, input logic focus);
    in_word_t w;
    w.scan_byte = scan;
    w.editor_focused = focus;
    key_backlog.push_back(w);
  endtask

  function automatic logic idle_allowed();
    return key_backlog.size() >= TailWords && (words_sent % 400) < 300;
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    logic [7:0] lead;
    int unsigned pick;
    // plain and shifted letters, shared shift flag
    push_key({1'b0, KEY_A}, 1'b1);
    push_key({1'b0, KEY_A}, 1'b0);
    push_key({1'b0, SC_LSHIFT}, 1'b1);
    push_key({1'b0, KEY_A}, 1'b1);
    push_key({1'b0, SC_KEY_1}, 1'b0);
    push_key(BREAK_BIT | {1'b0, SC_RSHIFT}, 1'b1);
    push_key({1'b0, KEY_A}, 1'b1);
    // caps lock, with and without shift
    push_key({1'b0, SC_CAPS}, 1'b1);
    push_key({1'b0, KEY_A}, 1'b1);
    push_key({1'b0, SC_RSHIFT}, 1'b0);
    push_key({1'b0, KEY_A}, 1'b0);
    push_key(BREAK_BIT | {1'b0, SC_LSHIFT}, 1'b1);
    push_key({1'b0, SC_CAPS}, 1'b1);
    // ctrl chords
    push_key({1'b0, SC_CTRL}, 1'b1);
    push_key({1'b0, SC_KEY_S}, 1'b1);
    push_key({1'b0, SC_KEY_S}, 1'b0);
    for (int k = 0; k < 4; k++) push_key({1'b0, SC_KEY_1 + 7'(k)}, k[0]);
    push_key({1'b0, KEY_Q}, 1'b1);
    push_key(BREAK_BIT | {1'b0, SC_CTRL}, 1'b0);
    // keys with no character, stray releases, byte extremes
    push_key(8'h00, 1'b1);
    push_key({1'b0, KEY_ALT}, 1'b1);
    push_key({1'b0, KEY_TOP}, 1'b0);
    push_key(8'hFF, 1'b1);
    push_key(BREAK_BIT | {1'b0, SC_KEY_S}, 1'b1);
    push_key({1'b0, KEY_SPACE}, 1'b0);

    while (key_backlog.size() < RandomWords + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_key(8'($urandom_range(0, 58)), $urandom_range(0, 3) != 0);
      end else if (pick < 65) begin
        case ($urandom_range(0, 4))
          0: lead = {1'b0, SC_LSHIFT};
          1: lead = {1'b0, SC_RSHIFT};
          2: lead = {1'b0, SC_CAPS};
          default: lead = {1'b0, SC_CTRL};
        endcase
        push_key(lead, 1'($urandom_range(0, 1)));
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0: lead = BREAK_BIT | {1'b0, SC_LSHIFT};
          1: lead = BREAK_BIT | {1'b0, SC_RSHIFT};
          default: lead = BREAK_BIT | {1'b0, SC_CTRL};
        endcase
        push_key(lead, 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        push_key({1'b0, SC_CTRL}, 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 2))
          0: lead = {1'b0, SC_KEY_S};
          1: lead = 8'($urandom_range(SC_KEY_1, SC_KEY_4));
          default: lead = 8'($urandom_range(0, 58));
        endcase
        push_key(lead, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) push_key(BREAK_BIT | {1'b0, SC_CTRL}, 1'b1);
      end else begin
        push_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  end

  always @(posedge clk) begin
    out_word_t ev;
    if (rst) begin
      key_valid <= 1'b0;
      key_gap <= 0;
    end else begin
      if (key_valid && !key_stall) begin
        if (translate_key(key_word, ev)) expected_events.push_back(ev);
        words_sent <= words_sent + 1;
      end
      if (!key_valid || !key_stall) begin
        if (key_gap > 0) begin
          key_valid <= 1'b0;
          key_gap <= key_gap - 1;
        end else if (key_backlog.size() == 0) begin
          key_valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
          key_valid <= 1'b0;
          key_gap <= $urandom_range(0, 3);
        end else begin
          key_word <= key_backlog.pop_front();
          key_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      event_stall <= 1'b0;
      stall_gap <= 0;
    end else begin
      if (event_valid && !event_stall) begin
        if (expected_events.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < MaxReports)
            $display("unexpected event: kind %0d char %h tab %0d", event_word.event_kind,
                     event_word.char_code, event_word.tab_index);
        end else begin
          want = expected_events.pop_front();
          if (event_word !== want) begin
            error_count <= error_count + 1;
            if (error_count < MaxReports)
              $display({"event mismatch: expected kind %0d char %h tab %0d, ",
                        "got kind %0d char %h tab %0d"},
                       want.event_kind, want.char_code, want.tab_index, event_word.event_kind,
                       event_word.char_code, event_word.tab_index);
          end
        end
      end
      if (stall_gap > 0) begin
        event_stall <= 1'b1;
        stall_gap <= stall_gap - 1;
      end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
        event_stall <= 1'b1;
        stall_gap <= $urandom_range(0, 3);
      end else begin
        event_stall <= 1'b0;
      end
    end
  end

  initial begin
    @(negedge rst);
    while (key_backlog.size() != 0 || key_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0 && error_count < MaxReports)
      $display("%0d expected events never arrived", expected_events.size());
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("scancode_to_ascii_with_modifiers_unit test passed");
    end else begin
      $display("scancode_to_ascii_with_modifiers_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("scancode_to_ascii_with_modifiers_unit test failed");
    $finish;
  end

endmodule
